FILE: sv/isg_pkg.sv
// shared types and constants for the imu sample gate
`default_nettype none

package isg_pkg;

   localparam int unsigned AxisWidth  = 16;
   localparam int unsigned LimitWidth = 15;
   localparam int unsigned MagWidth   = 16;
   localparam int unsigned StepWidth  = 4;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [LimitWidth-1:0] AccelLimitReset = 15'd25600;
   localparam logic [LimitWidth-1:0] GyroLimitReset  = 15'd32000;

   // last cycle of the serial multiply and of the serial root
   localparam logic [StepWidth-1:0] StepLast = 4'd15;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] RegAccelLimit = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegGyroLimit  = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROOT,
      ST_RESP
   } state_type;

   // magnitude of a signed axis value, -32768 maps to 32768
   function automatic logic [AxisWidth-1:0] axis_mag(input logic [AxisWidth-1:0] v);
      axis_mag = v[AxisWidth-1] ? (~v + 16'd1) : v;
   endfunction

endpackage

`default_nettype wire

FILE: sv/imu_sample_gate_with_magnitude.sv
// imu sample gate: range check, sample hold and serial vector magnitude
//
// One request word carries a six-axis sample; every request gives exactly one
// response word with the held sample, the accepted flag and the floor of the
// acceleration vector length. The first word after reset is always taken;
// later words are dropped when values_finite is low or any axis magnitude
// exceeds its limit (a value equal to the limit passes). A dropped word gives
// its response in the cycle after acceptance; once the response is taken the
// block returns to idle and can accept the next word. A taken word goes
// through a bit-serial sum of squares (one multiplier bit of all three axes
// per cycle into a right-shifting accumulator) and a restoring square root
// (one root bit per cycle); its response is valid when the root is done and
// the next word can be accepted after the response is taken. The block works
// on one word at a time: req_ready is high only in idle. Limits are written
// through the csr port while the block is idle, a rule for the user that the
// block itself does not enforce; writes to unknown indexes are ignored.
`default_nettype none

module imu_sample_gate_with_magnitude (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_we,
   input  wire logic [isg_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire logic [isg_pkg::LimitWidth-1:0]        csr_wdata,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [isg_pkg::AxisWidth-1:0]  req_accel_x,
   input  wire logic signed [isg_pkg::AxisWidth-1:0]  req_accel_y,
   input  wire logic signed [isg_pkg::AxisWidth-1:0]  req_accel_z,
   input  wire logic signed [isg_pkg::AxisWidth-1:0]  req_rate_x,
   input  wire logic signed [isg_pkg::AxisWidth-1:0]  req_rate_y,
   input  wire logic signed [isg_pkg::AxisWidth-1:0]  req_rate_z,
   input  wire logic                                  req_values_finite,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_accepted,
   output logic signed [isg_pkg::AxisWidth-1:0]       rsp_held_accel_x,
   output logic signed [isg_pkg::AxisWidth-1:0]       rsp_held_accel_y,
   output logic signed [isg_pkg::AxisWidth-1:0]       rsp_held_accel_z,
   output logic signed [isg_pkg::AxisWidth-1:0]       rsp_held_rate_x,
   output logic signed [isg_pkg::AxisWidth-1:0]       rsp_held_rate_y,
   output logic signed [isg_pkg::AxisWidth-1:0]       rsp_held_rate_z,
   output logic [isg_pkg::MagWidth-1:0]               rsp_accel_magnitude
);

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   isg_pkg::state_type state_ff, state_in;

   logic [isg_pkg::LimitWidth-1:0] accel_limit_ff, accel_limit_in;
   logic [isg_pkg::LimitWidth-1:0] gyro_limit_ff, gyro_limit_in;

   logic started_ff, started_in;
   logic accepted_ff, accepted_in;

   logic [isg_pkg::AxisWidth-1:0] held_ax_ff, held_ax_in;
   logic [isg_pkg::AxisWidth-1:0] held_ay_ff, held_ay_in;
   logic [isg_pkg::AxisWidth-1:0] held_az_ff, held_az_in;
   logic [isg_pkg::AxisWidth-1:0] held_rx_ff, held_rx_in;
   logic [isg_pkg::AxisWidth-1:0] held_ry_ff, held_ry_in;
   logic [isg_pkg::AxisWidth-1:0] held_rz_ff, held_rz_in;
   logic [isg_pkg::MagWidth-1:0]  held_mag_ff, held_mag_in;

   logic [isg_pkg::StepWidth-1:0] step_ff, step_in;

   // serial multiply: fixed multiplicands and right-shifting multiplier bits
   logic [15:0] mcand_x_ff, mcand_x_in;
   logic [15:0] mcand_y_ff, mcand_y_in;
   logic [15:0] mcand_z_ff, mcand_z_in;
   logic [15:0] mplr_x_ff, mplr_x_in;
   logic [15:0] mplr_y_ff, mplr_y_in;
   logic [15:0] mplr_z_ff, mplr_z_in;

   // product accumulator, reused as the radicand shift register
   logic [33:0] prod_ff, prod_in;

   // square root remainder and partial root
   logic [17:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;

   // ------------------------------------------------------------------
   // range check on the incoming word
   // ------------------------------------------------------------------
   logic [15:0] mag_ax, mag_ay, mag_az, mag_rx, mag_ry, mag_rz;
   logic        in_range;
   logic        take_word;
   logic        req_fire;

   assign mag_ax = isg_pkg::axis_mag(req_accel_x);
   assign mag_ay = isg_pkg::axis_mag(req_accel_y);
   assign mag_az = isg_pkg::axis_mag(req_accel_z);
   assign mag_rx = isg_pkg::axis_mag(req_rate_x);
   assign mag_ry = isg_pkg::axis_mag(req_rate_y);
   assign mag_rz = isg_pkg::axis_mag(req_rate_z);

   assign in_range = req_values_finite
                   && (mag_ax <= {1'b0, accel_limit_ff})
                   && (mag_ay <= {1'b0, accel_limit_ff})
                   && (mag_az <= {1'b0, accel_limit_ff})
                   && (mag_rx <= {1'b0, gyro_limit_ff})
                   && (mag_ry <= {1'b0, gyro_limit_ff})
                   && (mag_rz <= {1'b0, gyro_limit_ff});

   // first word after reset skips every check
   assign take_word = !started_ff || in_range;

   assign req_ready = (state_ff == isg_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // ------------------------------------------------------------------
   // datapath slices for one serial step
   // ------------------------------------------------------------------
   logic [18:0] pp_sum;     // accumulator top plus selected multiplicands
   logic [19:0] rem_trial;  // remainder with the next two radicand bits
   logic [19:0] sub_val;    // 4 * root + 1
   logic        root_bit;

   assign pp_sum = 19'(prod_ff[33:16])
                 + (mplr_x_ff[0] ? 19'(mcand_x_ff) : 19'd0)
                 + (mplr_y_ff[0] ? 19'(mcand_y_ff) : 19'd0)
                 + (mplr_z_ff[0] ? 19'(mcand_z_ff) : 19'd0);

   assign rem_trial = {rem_ff, prod_ff[31:30]};
   assign sub_val   = {2'b00, root_ff, 2'b01};
   assign root_bit  = (rem_trial >= sub_val);

   // ------------------------------------------------------------------
   // next state and outputs
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      accel_limit_in = accel_limit_ff;
      gyro_limit_in  = gyro_limit_ff;
      started_in     = started_ff;
      accepted_in    = accepted_ff;
      held_ax_in     = held_ax_ff;
      held_ay_in     = held_ay_ff;
      held_az_in     = held_az_ff;
      held_rx_in     = held_rx_ff;
      held_ry_in     = held_ry_ff;
      held_rz_in     = held_rz_ff;
      held_mag_in    = held_mag_ff;
      step_in        = step_ff;
      mcand_x_in     = mcand_x_ff;
      mcand_y_in     = mcand_y_ff;
      mcand_z_in     = mcand_z_ff;
      mplr_x_in      = mplr_x_ff;
      mplr_y_in      = mplr_y_ff;
      mplr_z_in      = mplr_z_ff;
      prod_in        = prod_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;

      // limit writes, only while idle by contract
      if (csr_we) begin
         unique case (csr_index)
            isg_pkg::RegAccelLimit: accel_limit_in = csr_wdata;
            isg_pkg::RegGyroLimit:  gyro_limit_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         isg_pkg::ST_IDLE: begin
            if (req_fire) begin
               accepted_in = take_word;
               if (take_word) begin
                  started_in = 1'b1;
                  held_ax_in = req_accel_x;
                  held_ay_in = req_accel_y;
                  held_az_in = req_accel_z;
                  held_rx_in = req_rate_x;
                  held_ry_in = req_rate_y;
                  held_rz_in = req_rate_z;
                  mcand_x_in = mag_ax;
                  mcand_y_in = mag_ay;
                  mcand_z_in = mag_az;
                  mplr_x_in  = mag_ax;
                  mplr_y_in  = mag_ay;
                  mplr_z_in  = mag_az;
                  prod_in    = '0;
                  step_in    = '0;
                  state_in   = isg_pkg::ST_MUL;
               end else begin
                  // dropped word answers with what is held
                  state_in = isg_pkg::ST_RESP;
               end
            end
         end

         isg_pkg::ST_MUL: begin
            // add this bit's partial products, shift the accumulator right
            prod_in   = {pp_sum, prod_ff[15:1]};
            mplr_x_in = mplr_x_ff >> 1;
            mplr_y_in = mplr_y_ff >> 1;
            mplr_z_in = mplr_z_ff >> 1;
            step_in   = step_ff + 4'd1;
            if (step_ff == isg_pkg::StepLast) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = isg_pkg::ST_ROOT;
            end
         end

         isg_pkg::ST_ROOT: begin
            // restoring root: two radicand bits in, one root bit out
            prod_in = {prod_ff[31:0], 2'b00};
            rem_in  = root_bit ? 18'(rem_trial - sub_val) : 18'(rem_trial);
            root_in = {root_ff[14:0], root_bit};
            step_in = step_ff + 4'd1;
            if (step_ff == isg_pkg::StepLast) begin
               held_mag_in = {root_ff[14:0], root_bit};
               state_in    = isg_pkg::ST_RESP;
            end
         end

         isg_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = isg_pkg::ST_IDLE;
            end
         end

         default: state_in = isg_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // state register and control
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= isg_pkg::ST_IDLE;
         accel_limit_ff <= isg_pkg::AccelLimitReset;
         gyro_limit_ff  <= isg_pkg::GyroLimitReset;
         started_ff     <= 1'b0;
         accepted_ff    <= 1'b0;
         held_ax_ff     <= '0;
         held_ay_ff     <= '0;
         held_az_ff     <= '0;
         held_rx_ff     <= '0;
         held_ry_ff     <= '0;
         held_rz_ff     <= '0;
         held_mag_ff    <= '0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         accel_limit_ff <= accel_limit_in;
         gyro_limit_ff  <= gyro_limit_in;
         started_ff     <= started_in;
         accepted_ff    <= accepted_in;
         held_ax_ff     <= held_ax_in;
         held_ay_ff     <= held_ay_in;
         held_az_ff     <= held_az_in;
         held_rx_ff     <= held_rx_in;
         held_ry_ff     <= held_ry_in;
         held_rz_ff     <= held_rz_in;
         held_mag_ff    <= held_mag_in;
         step_ff        <= step_in;
      end
   end

   // serial datapath, no reset needed
   always_ff @(posedge clock) begin
      mcand_x_ff <= mcand_x_in;
      mcand_y_ff <= mcand_y_in;
      mcand_z_ff <= mcand_z_in;
      mplr_x_ff  <= mplr_x_in;
      mplr_y_ff  <= mplr_y_in;
      mplr_z_ff  <= mplr_z_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
   end

   // ------------------------------------------------------------------
   // response word
   // ------------------------------------------------------------------
   assign rsp_valid           = (state_ff == isg_pkg::ST_RESP);
   assign rsp_accepted        = accepted_ff;
   assign rsp_held_accel_x    = held_ax_ff;
   assign rsp_held_accel_y    = held_ay_ff;
   assign rsp_held_accel_z    = held_az_ff;
   assign rsp_held_rate_x     = held_rx_ff;
   assign rsp_held_rate_y     = held_ry_ff;
   assign rsp_held_rate_z     = held_rz_ff;
   assign rsp_accel_magnitude = held_mag_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_first_word_taken: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !started_ff) |=> accepted_ff)
      else $error("first word after reset was dropped");

   a_not_finite_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_fire && started_ff && !req_values_finite) |=> !accepted_ff)
      else $error("word without finite flag was taken");

   a_root_ends_in_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == isg_pkg::ST_ROOT && step_ff == isg_pkg::StepLast)
      |=> (rsp_valid && rsp_accepted))
      else $error("square root did not end in an accepted response");

   a_resp_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
      else $error("block did not return to idle after response");

endmodule

`default_nettype wire

FILE: sim/imu_sample_gate_with_magnitude_checker.sv
// response checker for the imu sample gate: predicts each response word and compares it
module imu_sample_gate_with_magnitude_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [isg_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [isg_pkg::LimitWidth-1:0]        csr_wdata,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [isg_pkg::AxisWidth-1:0]  req_accel_x,
   input  logic signed [isg_pkg::AxisWidth-1:0]  req_accel_y,
   input  logic signed [isg_pkg::AxisWidth-1:0]  req_accel_z,
   input  logic signed [isg_pkg::AxisWidth-1:0]  req_rate_x,
   input  logic signed [isg_pkg::AxisWidth-1:0]  req_rate_y,
   input  logic signed [isg_pkg::AxisWidth-1:0]  req_rate_z,
   input  logic                                  req_values_finite,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_accepted,
   input  logic signed [isg_pkg::AxisWidth-1:0]  rsp_held_accel_x,
   input  logic signed [isg_pkg::AxisWidth-1:0]  rsp_held_accel_y,
   input  logic signed [isg_pkg::AxisWidth-1:0]  rsp_held_accel_z,
   input  logic signed [isg_pkg::AxisWidth-1:0]  rsp_held_rate_x,
   input  logic signed [isg_pkg::AxisWidth-1:0]  rsp_held_rate_y,
   input  logic signed [isg_pkg::AxisWidth-1:0]  rsp_held_rate_z,
   input  logic [isg_pkg::MagWidth-1:0]          rsp_accel_magnitude,
   output int                                    mismatch_count,
   output int                                    results_due
);

   typedef struct packed {
      logic signed [isg_pkg::AxisWidth-1:0] accel_x;
      logic signed [isg_pkg::AxisWidth-1:0] accel_y;
      logic signed [isg_pkg::AxisWidth-1:0] accel_z;
      logic signed [isg_pkg::AxisWidth-1:0] rate_x;
      logic signed [isg_pkg::AxisWidth-1:0] rate_y;
      logic signed [isg_pkg::AxisWidth-1:0] rate_z;
      logic                                 values_finite;
   } imu_sample_type;

   typedef struct packed {
      logic                                 accepted;
      logic signed [isg_pkg::AxisWidth-1:0] accel_x;
      logic signed [isg_pkg::AxisWidth-1:0] accel_y;
      logic signed [isg_pkg::AxisWidth-1:0] accel_z;
      logic signed [isg_pkg::AxisWidth-1:0] rate_x;
      logic signed [isg_pkg::AxisWidth-1:0] rate_y;
      logic signed [isg_pkg::AxisWidth-1:0] rate_z;
      logic [isg_pkg::MagWidth-1:0]         magnitude;
   } gate_result_type;

   localparam int NumFields = 8;

   logic [isg_pkg::LimitWidth-1:0] accel_lim;
   logic [isg_pkg::LimitWidth-1:0] gyro_lim;
   logic                           gate_started;
   gate_result_type                held_view;
   gate_result_type                gate_results_due[$];
   gate_result_type                due_word;
   gate_result_type                seen_word;
   imu_sample_type                 offered;
   int                             rsp_seen;
   longint                         due_field[NumFields];
   longint                         seen_field[NumFields];
   string                          field_name[NumFields] = '{"accepted", "held_accel_x",
      "held_accel_y", "held_accel_z", "held_rate_x", "held_rate_y", "held_rate_z",
      "accel_magnitude"};

   function automatic bit above_limit(input logic signed [isg_pkg::AxisWidth-1:0] v,
                                      input logic [isg_pkg::LimitWidth-1:0] lim);
      int m;
      m = v;
      if (m < 0) m = -m;
      return m > int'(lim);
   endfunction

   function automatic longint unsigned square_of(input logic signed [isg_pkg::AxisWidth-1:0] v);
      longint m;
      m = v;
      return longint'(m * m);
   endfunction

   // binary search for the largest root whose square fits
   function automatic logic [isg_pkg::MagWidth-1:0] floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = isg_pkg::MagWidth - 1; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      return root[isg_pkg::MagWidth-1:0];
   endfunction

   function automatic gate_result_type predict_gate(input imu_sample_type s);
      logic            take;
      gate_result_type r;
      take = 1'b1;
      // first word after reset is taken unchecked
      if (gate_started) begin
         if (!s.values_finite) take = 1'b0;
         if (above_limit(s.accel_x, accel_lim) || above_limit(s.accel_y, accel_lim) ||
             above_limit(s.accel_z, accel_lim)) take = 1'b0;
         if (above_limit(s.rate_x, gyro_lim) || above_limit(s.rate_y, gyro_lim) ||
             above_limit(s.rate_z, gyro_lim)) take = 1'b0;
      end
      if (take) begin
         held_view.accel_x   = s.accel_x;
         held_view.accel_y   = s.accel_y;
         held_view.accel_z   = s.accel_z;
         held_view.rate_x    = s.rate_x;
         held_view.rate_y    = s.rate_y;
         held_view.rate_z    = s.rate_z;
         held_view.magnitude = floor_root(square_of(s.accel_x) + square_of(s.accel_y) +
                                          square_of(s.accel_z));
         gate_started = 1'b1;
      end
      r = held_view;
      r.accepted = take;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         accel_lim      = isg_pkg::AccelLimitReset;
         gyro_lim       = isg_pkg::GyroLimitReset;
         gate_started   = 1'b0;
         held_view      = '0;
         rsp_seen       = 0;
         mismatch_count = 0;
         gate_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               isg_pkg::RegAccelLimit: accel_lim = csr_wdata;
               isg_pkg::RegGyroLimit:  gyro_lim  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            offered = '{req_accel_x, req_accel_y, req_accel_z, req_rate_x, req_rate_y,
                        req_rate_z, req_values_finite};
            gate_results_due.push_back(predict_gate(offered));
         end
         if (rsp_valid && rsp_ready) begin
            if (gate_results_due.size() == 0) begin
               flag_mismatch($sformatf("response word %0d with none outstanding", rsp_seen));
            end else begin
               due_word  = gate_results_due.pop_front();
               seen_word = '{rsp_accepted, rsp_held_accel_x, rsp_held_accel_y,
                             rsp_held_accel_z, rsp_held_rate_x, rsp_held_rate_y,
                             rsp_held_rate_z, rsp_accel_magnitude};
               due_field  = '{due_word.accepted, due_word.accel_x, due_word.accel_y,
                              due_word.accel_z, due_word.rate_x, due_word.rate_y,
                              due_word.rate_z, due_word.magnitude};
               seen_field = '{seen_word.accepted, seen_word.accel_x, seen_word.accel_y,
                              seen_word.accel_z, seen_word.rate_x, seen_word.rate_y,
                              seen_word.rate_z, seen_word.magnitude};
               for (int f = 0; f < NumFields; f++) begin
                  if (due_field[f] != seen_field[f])
                     flag_mismatch($sformatf("response word %0d %s expected %0d got %0d",
                                             rsp_seen, field_name[f], due_field[f],
                                             seen_field[f]));
               end
            end
            rsp_seen++;
         end
      end
      results_due = gate_results_due.size();
   end

endmodule

FILE: sim/imu_sample_gate_with_magnitude_test.sv
// testbench top for the imu sample gate: clock, reset, stimulus and verdict
module imu_sample_gate_with_magnitude_test;

   localparam int CycleLimit  = 1000000;
   localparam int IdlePause   = 4;
   localparam int DrainCycles = 40;
   localparam int PhaseCount  = 12;
   localparam int PhaseWords  = 150;
   localparam int HoldCycles  = 250;

   // indexes past the two limit registers, writes there must be ignored
   localparam logic [isg_pkg::CsrIdxWidth-1:0] RegUnusedA = 2'd2;
   localparam logic [isg_pkg::CsrIdxWidth-1:0] RegUnusedB = 2'd3;

   localparam logic [isg_pkg::AxisWidth-1:0] AxisMin = 16'h8000;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_we;
   logic [isg_pkg::CsrIdxWidth-1:0]      csr_index;
   logic [isg_pkg::LimitWidth-1:0]       csr_wdata;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [isg_pkg::AxisWidth-1:0] req_accel_x;
   logic signed [isg_pkg::AxisWidth-1:0] req_accel_y;
   logic signed [isg_pkg::AxisWidth-1:0] req_accel_z;
   logic signed [isg_pkg::AxisWidth-1:0] req_rate_x;
   logic signed [isg_pkg::AxisWidth-1:0] req_rate_y;
   logic signed [isg_pkg::AxisWidth-1:0] req_rate_z;
   logic                                 req_values_finite;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic                                 rsp_accepted;
   logic signed [isg_pkg::AxisWidth-1:0] rsp_held_accel_x;
   logic signed [isg_pkg::AxisWidth-1:0] rsp_held_accel_y;
   logic signed [isg_pkg::AxisWidth-1:0] rsp_held_accel_z;
   logic signed [isg_pkg::AxisWidth-1:0] rsp_held_rate_x;
   logic signed [isg_pkg::AxisWidth-1:0] rsp_held_rate_y;
   logic signed [isg_pkg::AxisWidth-1:0] rsp_held_rate_z;
   logic [isg_pkg::MagWidth-1:0]         rsp_accel_magnitude;

   int mismatch_count;
   int results_due;
   int cycle_count = 0;
   int rsp_taken   = 0;

   // limits as last written, used to aim random words at the boundaries
   int unsigned accel_lim_now;
   int unsigned gyro_lim_now;

   // sender burst bookkeeping
   int burst_left = 0;

   // receiver stall pattern and long hold-off
   int hold_left  = 0;
   int hold_mark  = 300;
   int mode_left  = 0;
   int ready_mode = 0;

   imu_sample_gate_with_magnitude u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_rate_x          (req_rate_x),
      .req_rate_y          (req_rate_y),
      .req_rate_z          (req_rate_z),
      .req_values_finite   (req_values_finite),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_held_accel_x    (rsp_held_accel_x),
      .rsp_held_accel_y    (rsp_held_accel_y),
      .rsp_held_accel_z    (rsp_held_accel_z),
      .rsp_held_rate_x     (rsp_held_rate_x),
      .rsp_held_rate_y     (rsp_held_rate_y),
      .rsp_held_rate_z     (rsp_held_rate_z),
      .rsp_accel_magnitude (rsp_accel_magnitude)
   );

   imu_sample_gate_with_magnitude_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_rate_x          (req_rate_x),
      .req_rate_y          (req_rate_y),
      .req_rate_z          (req_rate_z),
      .req_values_finite   (req_values_finite),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_held_accel_x    (rsp_held_accel_x),
      .rsp_held_accel_y    (rsp_held_accel_y),
      .rsp_held_accel_z    (rsp_held_accel_z),
      .rsp_held_rate_x     (rsp_held_rate_x),
      .rsp_held_rate_y     (rsp_held_rate_y),
      .rsp_held_rate_z     (rsp_held_rate_z),
      .rsp_accel_magnitude (rsp_accel_magnitude),
      .mismatch_count      (mismatch_count),
      .results_due         (results_due)
   );

   // 10 unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run-time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[imu_sample_gate_with_magnitude] ERROR");
         $finish;
      end
   end

   // response words taken, drives the hold-off trigger
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) rsp_taken <= rsp_taken + 1;
   end

   // receiver: stretches of always ready, random stalls and sparse ready,
   // plus a long hold-off now and then so the block backs up into its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_taken >= hold_mark) begin
         hold_left <= HoldCycles;
         hold_mark <= hold_mark + 800;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(2);
            mode_left  <= $urandom_range(80, 10);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(1) == 0);
            default: rsp_ready <= ($urandom_range(5) == 0);
         endcase
      end
   end

   // register write, one cycle of write enable
   task automatic write_csr(input logic [isg_pkg::CsrIdxWidth-1:0] idx,
                            input logic [isg_pkg::LimitWidth-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      if (idx == isg_pkg::RegAccelLimit) accel_lim_now = data;
      if (idx == isg_pkg::RegGyroLimit)  gyro_lim_now  = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // stop offering and wait for every outstanding response word
   task automatic settle_block(input int pause);
      req_valid = 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (pause) @(negedge clock);
   endtask

   // offer one word; called and returns at a falling edge
   task automatic send_word(input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az, input logic [15:0] rx,
                            input logic [15:0] ry, input logic [15:0] rz,
                            input logic finite);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      req_accel_x       = ax;
      req_accel_y       = ay;
      req_accel_z       = az;
      req_rate_x        = rx;
      req_rate_y        = ry;
      req_rate_z        = rz;
      req_values_finite = finite;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // random axis value whose magnitude stays within a limit, often right on it
   function automatic logic [15:0] in_range(input int unsigned lim);
      int mag;
      mag = ($urandom_range(4) == 0) ? lim : $urandom_range(lim, 0);
      return ($urandom_range(1) == 0) ? 16'(-mag) : 16'(mag);
   endfunction

   // mostly well-formed words, the rest over a limit, non-finite, raw or at -32768
   task automatic pick_sample(output logic [5:0][15:0] axes, output logic finite);
      int kind;
      int k;
      int unsigned lim;
      int mag;
      kind = $urandom_range(99);
      for (int i = 0; i < 6; i++) axes[i] = in_range(i < 3 ? accel_lim_now : gyro_lim_now);
      finite = 1'b1;
      k   = $urandom_range(5);
      lim = (k < 3) ? accel_lim_now : gyro_lim_now;
      if (kind < 60) begin
         // well-formed as is
      end else if (kind < 72) begin
         // one axis just past its limit
         mag = lim + 1 + $urandom_range(3);
         if (mag >= 32768) axes[k] = AxisMin;
         else axes[k] = ($urandom_range(1) == 0) ? 16'(-mag) : 16'(mag);
      end else if (kind < 82) begin
         finite = 1'b0;
      end else if (kind < 92) begin
         for (int i = 0; i < 6; i++) axes[i] = 16'($urandom);
         finite = 1'($urandom_range(1));
      end else begin
         axes[k] = AxisMin;
      end
   endtask

   initial begin
      logic [5:0][15:0] axes;
      logic             finite;
      logic [14:0]      lim_a;
      logic [14:0]      lim_g;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = isg_pkg::RegAccelLimit;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_accel_x       = '0;
      req_accel_y       = '0;
      req_accel_z       = '0;
      req_rate_x        = '0;
      req_rate_y        = '0;
      req_rate_z        = '0;
      req_values_finite = 1'b0;
      accel_lim_now     = isg_pkg::AccelLimitReset;
      gyro_lim_now      = isg_pkg::GyroLimitReset;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset limits: first word taken despite non-finite and -32768 axes
      send_word(AxisMin, AxisMin, AxisMin, AxisMin, AxisMin, AxisMin, 1'b0);
      send_word(0, 0, 0, 0, 0, 0, 1'b0);
      send_word(0, 0, 0, 0, 0, 0, 1'b1);
      // axes equal to their limits pass
      send_word(25600, -25600, 25600, 32000, -32000, 32000, 1'b1);
      // one past a limit on each axis, then -32768 axes and other patterns
      send_word(25601, 0, 0, 0, 0, 0, 1'b1);
      send_word(0, -25601, 0, 0, 0, 0, 1'b1);
      send_word(0, 0, 25601, 0, 0, 0, 1'b1);
      send_word(0, 0, 0, 32001, 0, 0, 1'b1);
      send_word(0, 0, 0, 0, -32001, 0, 1'b1);
      send_word(0, 0, 0, 0, 0, 32001, 1'b1);
      send_word(AxisMin, 0, 0, 0, 0, 0, 1'b1);
      send_word(0, 0, 0, 0, 0, AxisMin, 1'b1);
      send_word(32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
      send_word(1, -1, 1, -1, 1, -1, 1'b1);
      send_word(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1);

      // widest limits, spare indexes written with all ones
      settle_block(IdlePause);
      write_csr(RegUnusedA, 15'h7fff);
      write_csr(RegUnusedB, 15'h7fff);
      write_csr(isg_pkg::RegAccelLimit, 15'h7fff);
      write_csr(isg_pkg::RegGyroLimit, 15'h7fff);
      send_word(32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
      send_word(-32767, -32767, -32767, -32767, -32767, -32767, 1'b1);
      send_word(0, AxisMin, 0, 0, 0, 0, 1'b1);
      send_word(0, 0, 0, AxisMin, 0, 0, 1'b1);

      // zero limits: only an all-zero finite word passes
      settle_block(IdlePause);
      write_csr(isg_pkg::RegAccelLimit, 0);
      write_csr(isg_pkg::RegGyroLimit, 0);
      send_word(0, 0, 0, 0, 0, 0, 1'b1);
      send_word(0, 0, 1, 0, 0, 0, 1'b1);
      send_word(0, 0, 0, 0, -1, 0, 1'b1);
      send_word(0, 0, 0, 0, 0, 0, 1'b0);

      // random phases, each under its own limit setting
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: begin lim_a = 15'h7fff; lim_g = 15'h7fff; end
            1: begin lim_a = 0;        lim_g = 15'h7fff; end
            2: begin lim_a = 15'h7fff; lim_g = 0;        end
            3: begin lim_a = 1;        lim_g = 1;        end
            4: begin
               lim_a = isg_pkg::AccelLimitReset;
               lim_g = isg_pkg::GyroLimitReset;
            end
            default: begin
               lim_a = ($urandom_range(1) == 0) ? 15'($urandom_range(255))
                                                : 15'($urandom_range(32767));
               lim_g = ($urandom_range(1) == 0) ? 15'($urandom_range(255))
                                                : 15'($urandom_range(32767));
            end
         endcase
         settle_block(IdlePause);
         write_csr((phase % 2 == 0) ? RegUnusedA : RegUnusedB, 15'($urandom));
         write_csr(isg_pkg::RegAccelLimit, lim_a);
         write_csr(isg_pkg::RegGyroLimit, lim_g);
         repeat (PhaseWords) begin
            pick_sample(axes, finite);
            send_word(axes[0], axes[1], axes[2], axes[3], axes[4], axes[5], finite);
         end
      end

      // drain and give the verdict
      settle_block(DrainCycles);
      if (mismatch_count == 0) begin
         $display("[imu_sample_gate_with_magnitude] OK");
      end else begin
         $display("[imu_sample_gate_with_magnitude] ERROR");
      end
      $finish;
   end

endmodule

FILE: imu_sample_gate_with_magnitude.f
sv/isg_pkg.sv
sv/imu_sample_gate_with_magnitude.sv
sim/imu_sample_gate_with_magnitude_checker.sv
sim/imu_sample_gate_with_magnitude_test.sv
